FILE: hdl/bal_pkg.sv
// shared types and codes for the bounded array list
// request and result structs, request and status codes, cell commands
// no dependencies
package bal_pkg;

	localparam int DEPTH_DEF = 16;

	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_SEARCH     = 3'd4,
		REQ_REMOVE     = 3'd5
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD    = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_FROM_LO = 2'd2,
		CMD_FROM_HI = 2'd3
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      cmp;
		logic      live;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value;
	} bal_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         found_index;
		logic [4:0]         count;
		logic signed [31:0] removed_value;
	} bal_rsp_t;

endpackage

FILE: hdl/bounded_array_list.sv
// top level of the bounded array list: a row of bal_cell slots plus the
// request decode, count register and result register; depends on bal_pkg
//
// For each item, at the accepting edge every cell compares its entry
// with the value; in the next cycle (busy high) the first match is
// picked along the row of cells, the cells load or shift, and the
// result is registered. The result shows for one cycle with done high,
// the cycle after busy, and a new item may be accepted in that same
// cycle; no new item is accepted while busy is high. The first-match
// carry ripples through all DEPTH cells and sets the clock limit. The
// receiver cannot stall: a result not taken in its done cycle is gone.
module bounded_array_list import bal_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  bal_req_t req,
	output logic     busy,
	output logic     done,
	output bal_rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic               pend_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [2:0]         op_q;
	logic signed [31:0] val_q;
	bal_rsp_t           rsp_q;

	cell_ctl_t          ctl     [DEPTH];
	logic signed [31:0] entry   [DEPTH];
	logic               hit     [DEPTH+1];
	logic               first   [DEPTH];

	logic               accept;
	logic               full;
	logic               empty;
	logic [IW-1:0]      first_idx;
	logic signed [31:0] first_val;
	logic signed [31:0] last_val;
	logic [CW-1:0]      cnt_d;
	logic [1:0]         st_d;
	logic [IW-1:0]      idx_d;
	logic signed [31:0] rem_d;
	logic [IW+3:0]      idx_ext;
	logic [CW+4:0]      cnt_ext;

	assign accept = start && !pend_q;
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign hit[0] = 1'b0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [31:0] lo_n;
		logic signed [31:0] hi_n;
		if (g == 0) begin : g_lo_edge
			assign lo_n = val_q;
		end else begin : g_lo
			assign lo_n = entry[g-1];
		end
		if (g == DEPTH - 1) begin : g_hi_edge
			assign hi_n = entry[g];
		end else begin : g_hi
			assign hi_n = entry[g+1];
		end
		bal_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[g]),
			.key      (req.value),
			.load_val (val_q),
			.lo_entry (lo_n),
			.hi_entry (hi_n),
			.hit_in   (hit[g]),
			.entry    (entry[g]),
			.hit_out  (hit[g+1]),
			.first    (first[g])
		);
	end

	// one-hot selects folded into index and data
	always_comb begin
		first_idx = '0;
		first_val = '0;
		last_val  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				first_idx = first_idx | IW'(i);
				first_val = first_val | entry[i];
			end
			if (CW'(i + 1) == cnt_q) begin
				last_val = last_val | entry[i];
			end
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		st_d  = ST_OK;
		idx_d = '0;
		rem_d = '0;
		for (int i = 0; i < DEPTH; i++) begin
			ctl[i].cmd  = CMD_HOLD;
			ctl[i].cmp  = accept;
			ctl[i].live = (CW'(i) < cnt_q);
		end
		if (pend_q) begin
			unique case (op_q)
				REQ_PUSH_BACK: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						cnt_d = cnt_q + 1'b1;
						for (int i = 0; i < DEPTH; i++) begin
							if (CW'(i) == cnt_q) ctl[i].cmd = CMD_LOAD;
						end
					end
				end
				REQ_PUSH_FRONT: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						cnt_d = cnt_q + 1'b1;
						for (int i = 0; i < DEPTH; i++) begin
							ctl[i].cmd = (i == 0) ? CMD_LOAD : CMD_FROM_LO;
						end
					end
				end
				REQ_POP_FRONT: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						cnt_d = cnt_q - 1'b1;
						rem_d = entry[0];
						for (int i = 0; i < DEPTH; i++) begin
							ctl[i].cmd = CMD_FROM_HI;
						end
					end
				end
				REQ_POP_BACK: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						cnt_d = cnt_q - 1'b1;
						rem_d = last_val;
					end
				end
				REQ_SEARCH: begin
					if (hit[DEPTH]) begin
						idx_d = first_idx;
					end else begin
						st_d = ST_NOTFOUND;
					end
				end
				REQ_REMOVE: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else if (!hit[DEPTH]) begin
						st_d = ST_NOTFOUND;
					end else begin
						cnt_d = cnt_q - 1'b1;
						idx_d = first_idx;
						rem_d = first_val;
						// the match and everything behind it close the gap
						for (int i = 0; i < DEPTH; i++) begin
							if (hit[i+1]) ctl[i].cmd = CMD_FROM_HI;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign idx_ext = {4'b0, idx_d};
	assign cnt_ext = {5'b0, cnt_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			pend_q <= accept;
			done_q <= pend_q;
			if (pend_q) cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.req_type;
			val_q <= req.value;
		end
		if (pend_q) begin
			rsp_q.status        <= st_d;
			rsp_q.found_index   <= idx_ext[3:0];
			rsp_q.count         <= cnt_ext[4:0];
			rsp_q.removed_value <= rem_d;
		end
	end

	assign busy = pend_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hdl/bal_cell.sv
// one slot of the list: holds an entry, compares it against a key and
// shifts to or from its neighbors; depends on bal_pkg
module bal_cell import bal_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic signed [31:0] key,
	input  logic signed [31:0] load_val,
	input  logic signed [31:0] lo_entry,
	input  logic signed [31:0] hi_entry,
	input  logic               hit_in,
	output logic signed [31:0] entry,
	output logic               hit_out,
	output logic               first
);

	logic signed [31:0] entry_q;
	logic               match_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LOAD:    entry_q <= load_val;
			CMD_FROM_LO: entry_q <= lo_entry;
			CMD_FROM_HI: entry_q <= hi_entry;
			default:     entry_q <= entry_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= ctl.live && (entry_q == key);
		end
	end

	// running or of matches from the front of the row
	assign hit_out = hit_in | match_q;
	assign first   = match_q & ~hit_in;
	assign entry   = entry_q;

endmodule

FILE: sim/tb_bounded_array_list.sv
// testbench for bounded_array_list: a directed table, then random request mixes
// every result is checked against its table row, if flagged, or else a behavioral list predictor; uses bal_pkg
module tb_bounded_array_list import bal_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = DEPTH_DEF;
	localparam int LIMIT = 200000;
	localparam int RAND_PER_PHASE = 300;
	localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

	typedef struct packed {
		bal_req_t rq;
		logic     chk;
		bal_rsp_t rs;
	} dir_row_t;

	localparam int DIR_ROWS = 29;
	localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
		// empty list
		'{'{REQ_POP_FRONT,  32'sh0},        1'b1, '{ST_EMPTY,    4'd0, 5'd0, 32'sh0}},
		'{'{REQ_POP_BACK,   32'sh0},        1'b1, '{ST_EMPTY,    4'd0, 5'd0, 32'sh0}},
		'{'{REQ_REMOVE,     32'sh5},        1'b1, '{ST_EMPTY,    4'd0, 5'd0, 32'sh0}},
		'{'{REQ_SEARCH,     32'sh5},        1'b1, '{ST_NOTFOUND, 4'd0, 5'd0, 32'sh0}},
		'{'{REQ_UNUSED_6,   32'shffffffff}, 1'b1, '{ST_OK,       4'd0, 5'd0, 32'sh0}},
		'{'{REQ_PUSH_BACK,  32'sh7fffffff}, 1'b1, '{ST_OK,       4'd0, 5'd1, 32'sh0}},
		'{'{REQ_PUSH_FRONT, 32'sh80000000}, 1'b1, '{ST_OK,       4'd0, 5'd2, 32'sh0}},
		// fill up, with repeated words for first-match checks
		'{'{REQ_PUSH_BACK,  32'sh5},        1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh0},        1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'shffffffff}, 1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh55555555}, 1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'shaaaaaaaa}, 1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh5},        1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'sh1},        1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh5},        1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'shfffffffe}, 1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'sh12345678}, 1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh0},        1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh5},        1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh80000001}, 1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh7ffffffe}, 1'b0, '0},
		// full list
		'{'{REQ_PUSH_BACK,  32'sh9},        1'b1, '{ST_FULL,     4'd0, 5'd16, 32'sh0}},
		'{'{REQ_PUSH_FRONT, 32'sh9},        1'b1, '{ST_FULL,     4'd0, 5'd16, 32'sh0}},
		'{'{REQ_REMOVE,     32'sh9},        1'b1, '{ST_NOTFOUND, 4'd0, 5'd16, 32'sh0}},
		'{'{REQ_SEARCH,     32'sh5},        1'b0, '0},
		'{'{REQ_REMOVE,     32'sh5},        1'b0, '0},
		'{'{REQ_POP_FRONT,  32'sh0},        1'b0, '0},
		'{'{REQ_POP_BACK,   32'sh0},        1'b0, '0},
		'{'{REQ_UNUSED_7,   32'sh0},        1'b0, '0}
	};

	localparam int IDLE_TAB [0:2] = '{0, 72, 6};

	logic     clk;
	logic     arst_n;
	logic     start;
	bal_req_t req;
	logic     busy;
	logic     done;
	bal_rsp_t rsp;

	// predictor state
	logic [31:0] list_ent [DEPTH+1];
	int          list_cnt;

	bal_rsp_t pending_rsp [$];
	bal_rsp_t want_rsp;
	bal_rsp_t next_rsp;
	logic     cur_chk;
	bal_rsp_t cur_rs;
	int       idle_pct;
	int       acc_cnt;
	int       err_cnt;
	int       cyc;

	bounded_array_list #(.DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// applies one request to the predicted list and returns its result
	function automatic bal_rsp_t list_apply(bal_req_t r);
		bal_rsp_t o;
		bit       hit;
		int       pos;
		o = '0;
		hit = 0;
		pos = 0;
		for (int i = 0; i < list_cnt; i++) begin
			if (!hit && list_ent[i] == r.value) begin
				hit = 1;
				pos = i;
			end
		end
		case (r.req_type)
			REQ_PUSH_BACK: begin
				if (list_cnt >= DEPTH) o.status = ST_FULL;
				else begin
					list_ent[list_cnt] = r.value;
					list_cnt++;
				end
			end
			REQ_PUSH_FRONT: begin
				if (list_cnt >= DEPTH) o.status = ST_FULL;
				else begin
					for (int i = list_cnt; i > 0; i--) list_ent[i] = list_ent[i-1];
					list_ent[0] = r.value;
					list_cnt++;
				end
			end
			REQ_POP_FRONT: begin
				if (list_cnt == 0) o.status = ST_EMPTY;
				else begin
					o.removed_value = list_ent[0];
					for (int i = 0; i + 1 < list_cnt; i++) list_ent[i] = list_ent[i+1];
					list_cnt--;
				end
			end
			REQ_POP_BACK: begin
				if (list_cnt == 0) o.status = ST_EMPTY;
				else begin
					list_cnt--;
					o.removed_value = list_ent[list_cnt];
				end
			end
			REQ_SEARCH: begin
				if (hit) o.found_index = pos[3:0];
				else o.status = ST_NOTFOUND;
			end
			REQ_REMOVE: begin
				if (list_cnt == 0) o.status = ST_EMPTY;
				else if (!hit) o.status = ST_NOTFOUND;
				else begin
					o.found_index = pos[3:0];
					o.removed_value = list_ent[pos];
					for (int i = pos; i + 1 < list_cnt; i++) list_ent[i] = list_ent[i+1];
					list_cnt--;
				end
			end
			default: ;
		endcase
		o.count = list_cnt[4:0];
		return o;
	endfunction

	// words: a small pool so searches hit, words already stored, or anything
	function automatic logic [31:0] pick_word();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) return 32'($urandom_range(0, 7)) - 32'd2;
		if (sel < 75 && list_cnt > 0) return list_ent[$urandom_range(0, list_cnt - 1)];
		return $urandom;
	endfunction

	// grow mode leans to inserts, drain mode to removals
	function automatic bal_req_t rand_req(bit grow);
		bal_req_t r;
		int       sel;
		sel = $urandom_range(0, 99);
		r.value = pick_word();
		if (sel < 3) begin
			r.req_type = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
			r.value = $urandom;
		end else if (grow) begin
			if (sel < 33) r.req_type = REQ_PUSH_BACK;
			else if (sel < 58) r.req_type = REQ_PUSH_FRONT;
			else if (sel < 66) r.req_type = REQ_POP_FRONT;
			else if (sel < 74) r.req_type = REQ_POP_BACK;
			else if (sel < 89) r.req_type = REQ_SEARCH;
			else r.req_type = REQ_REMOVE;
		end else begin
			if (sel < 13) r.req_type = REQ_PUSH_BACK;
			else if (sel < 23) r.req_type = REQ_PUSH_FRONT;
			else if (sel < 48) r.req_type = REQ_POP_FRONT;
			else if (sel < 73) r.req_type = REQ_POP_BACK;
			else if (sel < 85) r.req_type = REQ_SEARCH;
			else r.req_type = REQ_REMOVE;
		end
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(input bal_req_t r, input logic chk, input bal_rsp_t rs);
		int n;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		cur_chk <= chk;
		cur_rs <= rs;
		n = acc_cnt;
		do @(negedge clk); while (acc_cnt == n);
	endtask

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10) $display("cycle %0d: result with none pending", cyc);
				end else begin
					want_rsp = pending_rsp.pop_front();
					if (rsp !== want_rsp) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("cycle %0d: exp st=%0d idx=%0d cnt=%0d rem=%h, got st=%0d idx=%0d cnt=%0d rem=%h",
								cyc, want_rsp.status, want_rsp.found_index, want_rsp.count,
								want_rsp.removed_value, rsp.status, rsp.found_index, rsp.count,
								rsp.removed_value);
					end
				end
			end
			if (start && !busy) begin
				next_rsp = list_apply(req);
				if (cur_chk) next_rsp = cur_rs;
				pending_rsp.push_back(next_rsp);
				acc_cnt++;
			end
		end
	end

	initial begin
		bal_req_t r;
		bit       grow;
		int       n;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cur_chk = 1'b0;
		cur_rs = '0;
		idle_pct = 0;
		acc_cnt = 0;
		err_cnt = 0;
		cyc = 0;
		list_cnt = 0;
		for (int i = 0; i <= DEPTH; i++) list_ent[i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) send_req(DIR_TAB[i].rq, DIR_TAB[i].chk, DIR_TAB[i].rs);

		grow = 1;
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = IDLE_TAB[ph];
			n = 0;
			while (n < RAND_PER_PHASE) begin
				r = rand_req(grow);
				send_req(r, 1'b0, '0);
				// unused codes are ignored by the block
				if (r.req_type <= REQ_REMOVE) n++;
				if ($urandom_range(0, 39) == 0) grow = !grow;
			end
		end
		start <= 1'b0;

		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (err_cnt == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
